// ===== rtl/dmavg_pkg.sv =====
// ----------------------------------------------------------------------------
// dmavg_pkg
// Shared types and constants for the decimated moving-average core.
// ----------------------------------------------------------------------------
package dmavg_pkg;

   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned LEN_CFG_W  = 7;

   localparam logic [CSR_IDX_W-1:0] REG_SKIP_COUNT    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = CSR_IDX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_FINISH
   } dmavg_state_type;

endpackage

// ===== rtl/dmavg_if.sv =====
// ----------------------------------------------------------------------------
// dmavg channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface dmavg_req_if #(parameter int unsigned SAMPLE_BITS = 10);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dmavg_rsp_if #(parameter int unsigned SAMPLE_BITS = 10);
   logic                   valid;
   logic                   ready;
   logic                   taken;
   logic [SAMPLE_BITS-1:0] sample_out;
   logic [SAMPLE_BITS-1:0] average;

   modport source (output valid, output taken, output sample_out, output average,
                   input ready);
   modport sink   (input valid, input taken, input sample_out, input average,
                   output ready);
endinterface

interface dmavg_csr_if;
   import dmavg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/decimated_moving_average_core.sv =====
// skipped tick: straight from idle to finish, where the result is registered once the
//   result channel is free; taken tick: ring read, SUM_W restoring divide steps, then finish
// no new transfer is accepted until the core is back in idle, so the serial divider by the
//   window length and result-channel stalls set the taken-tick rate
// synchronous reset clears control, sum and mean; the ring needs no clearing
//   pass as a wrap flag masks entries not yet rewritten
// ----------------------------------------------------------------------------
// decimated_moving_average_core
// Decimates a sample stream and returns the running mean over a ring window.
// ----------------------------------------------------------------------------
module decimated_moving_average_core #(
   parameter int unsigned MAX_WINDOW  = 64,
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   dmavg_req_if.sink   req_chan,
   dmavg_rsp_if.source rsp_chan,
   dmavg_csr_if.sink   csr_chan
);
   import dmavg_pkg::*;

   localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW + 1);
   localparam int unsigned CNT_W = $clog2(SUM_W + 1);

   dmavg_state_type        state_ff, state_in;
   logic [TICK_W-1:0]      skip_ff, skip_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [IDX_W-1:0]       widx_ff, widx_in;
   logic                   wrap_ff, wrap_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   take_ff, take_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic                   taken_ff, taken_in;
   logic [SAMPLE_BITS-1:0] sample_out_ff, sample_out_in;
   logic [SAMPLE_BITS-1:0] average_ff, average_in;

   logic [SAMPLE_BITS-1:0] win_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] mem_rd_ff;
   logic                   mem_we;

   logic                   req_xfer;
   logic                   csr_xfer;
   logic [SAMPLE_BITS-1:0] old_entry;
   logic [LEN_W:0]         rem_sh;
   logic                   quo_bit;
   logic [SUM_W-1:0]       quo_nxt;
   logic [LEN_W-1:0]       widx_nxt;
   logic [31:0]            len_req;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign csr_xfer       = csr_chan.valid && csr_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.taken      = taken_ff;
   assign rsp_chan.sample_out = sample_out_ff;
   assign rsp_chan.average    = average_ff;

   // entries not rewritten since the last clear read as zero
   assign old_entry = wrap_ff ? mem_rd_ff : '0;

   // one restoring divide step
   assign rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
   assign quo_bit = (rem_sh >= {1'b0, len_ff});
   assign quo_nxt = {quo_ff[SUM_W-2:0], quo_bit};

   assign widx_nxt = LEN_W'(widx_ff) + LEN_W'(1);
   assign mem_we   = (state_ff == ST_READ);

   always_comb begin
      state_in      = state_ff;
      skip_in       = skip_ff;
      tick_in       = tick_ff;
      len_in        = len_ff;
      widx_in       = widx_ff;
      wrap_in       = wrap_ff;
      sum_in        = sum_ff;
      mean_in       = mean_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      sample_in     = sample_ff;
      take_in       = take_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      taken_in      = taken_ff;
      sample_out_in = sample_out_ff;
      average_in    = average_ff;
      len_req       = 32'(csr_chan.data[LEN_CFG_W-1:0]);

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sample_in = req_chan.sample;
               if (tick_ff >= skip_ff) begin
                  tick_in  = '0;
                  take_in  = 1'b1;
                  state_in = ST_READ;
               end else begin
                  tick_in  = tick_ff + TICK_W'(1);
                  take_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            sum_in = sum_ff - SUM_W'(old_entry) + SUM_W'(sample_ff);
            quo_in = sum_ff - SUM_W'(old_entry) + SUM_W'(sample_ff);
            rem_in = '0;
            cnt_in = CNT_W'(SUM_W - 1);
            if (widx_nxt == len_ff) begin
               widx_in = '0;
               wrap_in = 1'b1;
            end else begin
               widx_in = IDX_W'(widx_nxt);
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            quo_in = quo_nxt;
            rem_in = quo_bit ? LEN_W'(rem_sh - {1'b0, len_ff}) : LEN_W'(rem_sh);
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               mean_in  = quo_nxt[SAMPLE_BITS-1:0];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               taken_in      = take_ff;
               sample_out_in = take_ff ? sample_ff : '0;
               average_in    = mean_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_xfer) begin
         case (csr_chan.index)
            REG_SKIP_COUNT: begin
               skip_in = csr_chan.data[TICK_W-1:0];
               tick_in = '0;
            end
            REG_WINDOW_LENGTH: begin
               if (len_req == 32'd0) begin
                  len_req = 32'd1;
               end
               if (len_req > 32'(MAX_WINDOW)) begin
                  len_req = 32'(MAX_WINDOW);
               end
               len_in  = LEN_W'(len_req);
               widx_in = '0;
               wrap_in = 1'b0;
               sum_in  = '0;
               mean_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         skip_ff      <= '0;
         tick_ff      <= '0;
         len_ff       <= LEN_W'(1);
         widx_ff      <= '0;
         wrap_ff      <= 1'b0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         skip_ff      <= skip_in;
         tick_ff      <= tick_in;
         len_ff       <= len_in;
         widx_ff      <= widx_in;
         wrap_ff      <= wrap_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      take_ff       <= take_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      taken_ff      <= taken_in;
      sample_out_ff <= sample_out_in;
      average_ff    <= average_in;
   end

   // ring store: read the slot about to be overwritten, write the new sample there next cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[widx_ff] <= sample_ff;
      end
      mem_rd_ff <= win_mem[widx_ff];
   end

`ifndef SYNTHESIS
   a_widx_in_window: assert property (@(posedge clock) disable iff (reset)
      LEN_W'(widx_ff) < len_ff)
      else $error("ring write index beyond window length");

   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < len_ff))
      else $error("divider remainder not below window length");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("core idle right after an input transfer");

   a_skipped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !taken_ff) |-> (sample_out_ff == '0))
      else $error("skipped tick carries a non-zero sample");
`endif

endmodule

// ===== verif/dmavg_result_checker.sv =====
// ----------------------------------------------------------------------------
// dmavg_result_checker
// Watches the sample, result and register channels of the decimated
// moving-average core. It keeps its own copy of the tick counter, the ring
// and the mean, works out the result of every accepted tick, and compares
// each returned result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module dmavg_result_checker (
   input  logic  clock,
   input  logic  reset,
   dmavg_req_if  req_bus,
   dmavg_rsp_if  rsp_bus,
   dmavg_csr_if  csr_bus,
   output int    mismatch_count,
   output int    results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import dmavg_pkg::*;

   localparam int unsigned RING_DEPTH = 64;
   localparam int unsigned SAMPLE_W   = 10;

   typedef struct packed {
      logic                taken;
      logic [SAMPLE_W-1:0] sample_out;
      logic [SAMPLE_W-1:0] average;
   } tick_result_type;

   logic [TICK_W-1:0]   skip_cfg;
   logic [TICK_W-1:0]   tick_cnt;
   int unsigned         span;
   int unsigned         wr_pos;
   logic [SAMPLE_W-1:0] ring [RING_DEPTH];
   logic [SAMPLE_W-1:0] mean_hold;
   tick_result_type     expected_ticks [$];

   function automatic void clear_ring();
      foreach (ring[i]) ring[i] = '0;
      wr_pos    = 0;
      mean_hold = '0;
   endfunction

   function automatic void write_register(input logic [CSR_IDX_W-1:0]  idx,
                                          input logic [CSR_DATA_W-1:0] value);
      int unsigned len;
      case (idx)
         REG_SKIP_COUNT: begin
            skip_cfg = value[TICK_W-1:0];
            tick_cnt = '0;
         end
         REG_WINDOW_LENGTH: begin
            len = 32'(value[LEN_CFG_W-1:0]);
            if (len == 0) begin
               len = 1;
            end else if (len > RING_DEPTH) begin
               len = RING_DEPTH;
            end
            span = len;
            clear_ring();
         end
         default: ;
      endcase
   endfunction

   function automatic tick_result_type predict_tick(input logic [SAMPLE_W-1:0] s);
      tick_result_type r;
      int unsigned     total;
      r = '0;
      if (tick_cnt >= skip_cfg) begin
         tick_cnt     = '0;
         r.taken      = 1'b1;
         r.sample_out = s;
         if (wr_pos >= span) wr_pos = 0;
         ring[wr_pos] = s;
         wr_pos++;
         if (wr_pos >= span) wr_pos = 0;
         total = 0;
         // entries never written since the last clear still count as zero
         for (int i = 0; i < span; i++) total += ring[i];
         mean_hold = SAMPLE_W'(total / span);
      end else begin
         tick_cnt = tick_cnt + 1'b1;
      end
      r.average = mean_hold;
      return r;
   endfunction

   function automatic void check_field(input string               name,
                                       input logic [SAMPLE_W-1:0] want,
                                       input logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         skip_cfg = '0;
         tick_cnt = '0;
         span     = 1;
         clear_ring();
         expected_ticks.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) write_register(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            expected_ticks.push_back(predict_tick(req_bus.sample));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ticks.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no tick outstanding, expected none actual %0d/%0d/%0d",
                        $time, rsp_bus.taken, rsp_bus.sample_out, rsp_bus.average);
            end else begin
               want = expected_ticks.pop_front();
               check_field("taken", SAMPLE_W'(want.taken), SAMPLE_W'(rsp_bus.taken));
               check_field("sample_out", want.sample_out, rsp_bus.sample_out);
               check_field("average", want.average, rsp_bus.average);
            end
         end
      end
      results_outstanding = expected_ticks.size();
   end

endmodule

// ===== verif/decimated_moving_average_core_tb.sv =====
// ----------------------------------------------------------------------------
// decimated_moving_average_core_tb
// Drives converter ticks and register writes into the decimated moving-average
// core: a directed pass over the field extremes and register corner cases,
// then random phases under several skip and window settings, with bursty
// sample traffic and a stalling result receiver. The result checker beside
// the core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module decimated_moving_average_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dmavg_pkg::*;

   localparam int unsigned SAMPLE_W        = 10;
   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int unsigned RANDOM_PHASES   = 6;
   localparam int unsigned TICKS_PER_PHASE = 225;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned HOLD_AT_RESULT  = 500;
   localparam int unsigned DRAIN_CYCLES    = 25;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LOW = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_TOP = '1;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int          mismatch_count;
   int          results_outstanding;

   dmavg_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan ();
   dmavg_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_chan ();
   dmavg_csr_if                           csr_chan ();

   decimated_moving_average_core #(
      .MAX_WINDOW  (64),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   dmavg_result_checker result_check (
      .clock               (clock),
      .reset               (reset),
      .req_bus             (req_chan),
      .rsp_bus             (rsp_chan),
      .csr_bus             (csr_chan),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decimated_moving_average_core_tb: done, errors");
         $finish;
      end
   end

   // offer one tick, opening a new burst after a random gap when the old one ends
   task automatic drive_tick(input logic [SAMPLE_W-1:0] s);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0]  idx,
                               input logic [CSR_DATA_W-1:0] value);
      pause_until_drained();
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // result receiver: stretches of steady, light and heavy stalling, plus one long hold
   initial begin
      int unsigned accepted;
      int unsigned hold_left;
      int unsigned stretch_left;
      int unsigned style;
      bit          held;
      accepted     = 0;
      hold_left    = 0;
      stretch_left = 0;
      style        = 0;
      held         = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) accepted++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!held && accepted == HOLD_AT_RESULT) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (stretch_left == 0) begin
               style        = $urandom_range(0, 3);
               stretch_left = $urandom_range(20, 150);
            end
            stretch_left--;
            case (style)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               2:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin
      logic [CSR_DATA_W-1:0] skip_val;
      logic [CSR_DATA_W-1:0] len_val;
      logic [SAMPLE_W-1:0]   s;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      csr_chan.valid  <= 1'b0;
      csr_chan.index  <= '0;
      csr_chan.data   <= '0;
      reset           <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every tick taken, window of one
      drive_tick(10'h3FF);
      drive_tick(10'h000);
      drive_tick(10'h2AA);
      drive_tick(10'h155);

      // widest window, early means still dragged down by cleared entries
      set_register(REG_WINDOW_LENGTH, 16'd64);
      repeat (3) drive_tick(10'h3FF);

      // longest skip: nothing taken, mean held
      set_register(REG_SKIP_COUNT, 16'hFFFF);
      drive_tick(10'h3FF);
      drive_tick(10'h001);

      set_register(REG_SKIP_COUNT, 16'd1);
      drive_tick(10'h200);
      drive_tick(10'h100);
      drive_tick(10'h3FE);

      // writes to unmapped indexes change nothing
      set_register(REG_UNMAPPED_LOW, 16'hFFFF);
      set_register(REG_UNMAPPED_TOP, 16'h0000);
      drive_tick(10'h0F0);

      // zero length taken as one, oversize saturates, only the low seven bits count
      set_register(REG_WINDOW_LENGTH, 16'd0);
      drive_tick(10'h3FF);
      drive_tick(10'h3FF);
      set_register(REG_WINDOW_LENGTH, 16'h007F);
      drive_tick(10'h3FF);
      drive_tick(10'h3FF);
      set_register(REG_WINDOW_LENGTH, 16'hFF80);
      drive_tick(10'h37F);

      set_register(REG_SKIP_COUNT, 16'd0);
      set_register(REG_WINDOW_LENGTH, 16'd2);
      drive_tick(10'h3FF);
      drive_tick(10'h3FF);
      drive_tick(10'h000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               skip_val = 16'd0;
               len_val  = 16'd64;
            end
            1: begin
               skip_val = 16'($urandom_range(0, 3));
               len_val  = 16'($urandom_range(1, 64));
            end
            2: begin
               skip_val = 16'd0;
               len_val  = 16'd1;
            end
            3: begin
               skip_val = 16'($urandom);
               len_val  = 16'($urandom_range(1, 64));
            end
            4: begin
               skip_val = 16'($urandom_range(1, 5));
               len_val  = 16'($urandom_range(2, 16));
            end
            default: begin
               skip_val = 16'($urandom_range(0, 2));
               len_val  = 16'($urandom);
            end
         endcase
         set_register(REG_SKIP_COUNT, skip_val);
         set_register(REG_WINDOW_LENGTH, len_val);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (p == 1 && n == 100) pause_until_drained();
            s = ($urandom_range(0, 9) == 0) ?
                (($urandom_range(0, 1) == 1) ? 10'h3FF : 10'h000) :
                SAMPLE_W'($urandom_range(0, 1023));
            drive_tick(s);
         end
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("decimated_moving_average_core_tb: done, clean");
      end else begin
         $display("decimated_moving_average_core_tb: done, errors");
      end
      $finish;
   end

endmodule
